### rtl/glfph_pkg.sv
// ----------------------------------------------------------------------------
// Gain/loss first-passage histogram package
// Shared widths, register indexes, defaults and the per-cell control bundle.
// ----------------------------------------------------------------------------
package glfph_pkg;

    localparam int DEF_MAX_LAG      = 32;
    localparam int DEF_SAMPLE_WIDTH = 32;
    localparam int DEF_COUNT_WIDTH  = 32;

    localparam int LAG_WIDTH       = 6;
    localparam int THRESH_WIDTH    = 31;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 31;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LAG_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_THRESHOLD = 2'd1;

    localparam logic [LAG_WIDTH-1:0]    LAG_LIMIT_RESET = 6'd32;
    localparam logic [THRESH_WIDTH-1:0] THRESHOLD_RESET = 31'd655;

    typedef struct packed {
        logic step;
        logic clear_window;
        logic shift_bins;
        logic clear_bins;
    } cell_ctrl_t;

endpackage

### rtl/gain_loss_first_passage_histogram.sv
// ----------------------------------------------------------------------------
// Gain/loss first-passage histogram
// Counts, per lag, the earlier samples that first see a rise or a fall of at
// least the threshold at that lag, and reads the histogram out at series end.
//
//   Channel   Direction  Handshake            Payload
//   input     in         in_valid / in_stall  sample, series_end
//   output    out        out_valid / out_stall lag, gain_count, loss_count,
//                                             final_bin
//   config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A sample is taken every cycle while the series runs; one comparison cell per
// lag works on it in parallel. After a series end one bin per lag is read out,
// up to the lag limit clamped to 1..MAX_LAG; the bins shift through the row of
// cells towards the output register and no sample is taken. Output stalls hold
// the read-out. Reset clears window and histogram and resets the config regs.
// ----------------------------------------------------------------------------
module gain_loss_first_passage_histogram #(
    parameter int MAX_LAG      = glfph_pkg::DEF_MAX_LAG,
    parameter int SAMPLE_WIDTH = glfph_pkg::DEF_SAMPLE_WIDTH,
    parameter int COUNT_WIDTH  = glfph_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [SAMPLE_WIDTH-1:0]               sample,
    input  logic                                  series_end,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [glfph_pkg::LAG_WIDTH-1:0]       lag,
    output logic [COUNT_WIDTH-1:0]                gain_count,
    output logic [COUNT_WIDTH-1:0]                loss_count,
    output logic                                  final_bin,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [glfph_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [glfph_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import glfph_pkg::*;

    localparam int IDX_W = LAG_WIDTH + 1;

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [LAG_WIDTH-1:0]    lag_limit_reg;
    logic [THRESH_WIDTH-1:0] threshold_reg;
    logic [LAG_WIDTH-1:0]    eff_limit;
    logic [LAG_WIDTH-1:0]    lim_reg, lim_next;
    logic [LAG_WIDTH-1:0]    emit_lag_reg, emit_lag_next;

    logic                   out_valid_reg, out_valid_next;
    logic [LAG_WIDTH-1:0]   lag_reg;
    logic [COUNT_WIDTH-1:0] gain_count_reg;
    logic [COUNT_WIDTH-1:0] loss_count_reg;
    logic                   final_bin_reg;

    logic       in_take;
    logic       out_load;
    logic       emit_last;
    cell_ctrl_t ctrl;

    logic [MAX_LAG-1:0]      cell_en;
    logic [SAMPLE_WIDTH-1:0] win_value [MAX_LAG];
    logic [MAX_LAG-1:0]      win_valid;
    logic [MAX_LAG-1:0]      win_gain_pend;
    logic [MAX_LAG-1:0]      win_loss_pend;
    logic [COUNT_WIDTH-1:0]  gain_bins [MAX_LAG];
    logic [COUNT_WIDTH-1:0]  loss_bins [MAX_LAG];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_limit_reg <= LAG_LIMIT_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LAG_LIMIT: lag_limit_reg <= cfg_data[LAG_WIDTH-1:0];
                REG_THRESHOLD: threshold_reg <= cfg_data[THRESH_WIDTH-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        if (lag_limit_reg == '0)
        begin
            eff_limit = LAG_WIDTH'(1);
        end
        else if ({1'b0, lag_limit_reg} > IDX_W'(MAX_LAG))
        begin
            eff_limit = LAG_WIDTH'(MAX_LAG);
        end
        else
        begin
            eff_limit = lag_limit_reg;
        end
    end

    assign in_stall  = (state_reg != ST_RUN);
    assign in_take   = in_valid && !in_stall;
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign emit_last = (emit_lag_reg == lim_reg);

    always_comb
    begin
        ctrl.step         = in_take;
        ctrl.clear_window = in_take && series_end;
        ctrl.shift_bins   = out_load;
        ctrl.clear_bins   = out_load && emit_last;
    end

    always_comb
    begin
        state_next     = state_reg;
        lim_next       = lim_reg;
        emit_lag_next  = emit_lag_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_RUN:
            begin
                if (in_take && series_end)
                begin
                    state_next    = ST_EMIT;
                    lim_next      = eff_limit;
                    emit_lag_next = LAG_WIDTH'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    emit_lag_next = emit_lag_reg + LAG_WIDTH'(1);
                    if (emit_last)
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            lim_reg       <= LAG_WIDTH'(1);
            emit_lag_reg  <= LAG_WIDTH'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lim_reg       <= lim_next;
            emit_lag_reg  <= emit_lag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            lag_reg        <= emit_lag_reg;
            gain_count_reg <= gain_bins[0];
            loss_count_reg <= loss_bins[0];
            final_bin_reg  <= emit_last;
        end
    end

    genvar k;
    generate
        for (k = 0; k < MAX_LAG; k++)
        begin : g_cell
            logic [SAMPLE_WIDTH-1:0] prev_value;
            logic                    prev_valid;
            logic                    prev_gain_pend;
            logic                    prev_loss_pend;
            logic [COUNT_WIDTH-1:0]  upper_gain;
            logic [COUNT_WIDTH-1:0]  upper_loss;

            assign cell_en[k] = (IDX_W'(k) < {1'b0, eff_limit});

            if (k == 0)
            begin : g_head
                assign prev_value     = sample;
                assign prev_valid     = 1'b1;
                assign prev_gain_pend = 1'b1;
                assign prev_loss_pend = 1'b1;
            end
            else
            begin : g_body
                assign prev_value     = win_value[k-1];
                assign prev_valid     = win_valid[k-1];
                assign prev_gain_pend = win_gain_pend[k-1];
                assign prev_loss_pend = win_loss_pend[k-1];
            end

            if (k == MAX_LAG - 1)
            begin : g_tail
                assign upper_gain = '0;
                assign upper_loss = '0;
            end
            else
            begin : g_inner
                assign upper_gain = gain_bins[k+1];
                assign upper_loss = loss_bins[k+1];
            end

            glfph_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .COUNT_WIDTH  (COUNT_WIDTH)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .ctrl           (ctrl),
                .en             (cell_en[k]),
                .new_sample     (sample),
                .threshold      (threshold_reg),
                .prev_value     (prev_value),
                .prev_valid     (prev_valid),
                .prev_gain_pend (prev_gain_pend),
                .prev_loss_pend (prev_loss_pend),
                .value          (win_value[k]),
                .valid          (win_valid[k]),
                .gain_pend      (win_gain_pend[k]),
                .loss_pend      (win_loss_pend[k]),
                .upper_gain_bin (upper_gain),
                .upper_loss_bin (upper_loss),
                .gain_bin       (gain_bins[k]),
                .loss_bin       (loss_bins[k])
            );
        end
    endgenerate

    assign out_valid  = out_valid_reg;
    assign lag        = lag_reg;
    assign gain_count = gain_count_reg;
    assign loss_count = loss_count_reg;
    assign final_bin  = final_bin_reg;

endmodule

### rtl/glfph_cell.sv
// ----------------------------------------------------------------------------
// Histogram cell
// Holds one window entry with its pending flags and the gain and loss bins
// of one lag. Window entries move one cell down per sample; bins move one
// cell towards the output while a histogram is read out.
// ----------------------------------------------------------------------------
module glfph_cell #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  glfph_pkg::cell_ctrl_t              ctrl,
    input  logic                               en,
    input  logic [SAMPLE_WIDTH-1:0]            new_sample,
    input  logic [glfph_pkg::THRESH_WIDTH-1:0] threshold,
    input  logic [SAMPLE_WIDTH-1:0]            prev_value,
    input  logic                               prev_valid,
    input  logic                               prev_gain_pend,
    input  logic                               prev_loss_pend,
    output logic [SAMPLE_WIDTH-1:0]            value,
    output logic                               valid,
    output logic                               gain_pend,
    output logic                               loss_pend,
    input  logic [COUNT_WIDTH-1:0]             upper_gain_bin,
    input  logic [COUNT_WIDTH-1:0]             upper_loss_bin,
    output logic [COUNT_WIDTH-1:0]             gain_bin,
    output logic [COUNT_WIDTH-1:0]             loss_bin
);
    import glfph_pkg::*;

    localparam int DW = ((SAMPLE_WIDTH + 1 > THRESH_WIDTH + 1) ?
                         SAMPLE_WIDTH + 1 : THRESH_WIDTH + 1) + 1;

    logic [SAMPLE_WIDTH-1:0] value_reg;
    logic                    valid_reg, valid_next;
    logic                    gain_pend_reg, gain_pend_next;
    logic                    loss_pend_reg, loss_pend_next;
    logic [COUNT_WIDTH-1:0]  gain_bin_reg, gain_bin_next;
    logic [COUNT_WIDTH-1:0]  loss_bin_reg, loss_bin_next;

    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] th_ext;
    logic signed [DW-1:0] diff_plus_th;
    logic                 gain_hit;
    logic                 loss_hit;

    assign diff = DW'($signed(new_sample)) - DW'($signed(value_reg));
    assign th_ext = $signed({{(DW - THRESH_WIDTH){1'b0}}, threshold});
    assign diff_plus_th = diff + th_ext;

    assign gain_hit = ctrl.step && en && valid_reg && gain_pend_reg && (diff >= th_ext);
    assign loss_hit = ctrl.step && en && valid_reg && loss_pend_reg &&
                      (diff_plus_th <= $signed(DW'(0)));

    always_comb
    begin
        valid_next     = valid_reg;
        gain_pend_next = gain_pend_reg && !gain_hit;
        loss_pend_next = loss_pend_reg && !loss_hit;
        if (ctrl.step)
        begin
            if (ctrl.clear_window)
            begin
                valid_next     = 1'b0;
                gain_pend_next = 1'b0;
                loss_pend_next = 1'b0;
            end
            else
            begin
                valid_next     = prev_valid;
                gain_pend_next = prev_gain_pend;
                loss_pend_next = prev_loss_pend;
            end
        end
    end

    always_comb
    begin
        gain_bin_next = gain_bin_reg;
        loss_bin_next = loss_bin_reg;
        if (ctrl.clear_bins)
        begin
            gain_bin_next = '0;
            loss_bin_next = '0;
        end
        else if (ctrl.shift_bins)
        begin
            gain_bin_next = upper_gain_bin;
            loss_bin_next = upper_loss_bin;
        end
        else
        begin
            if (gain_hit && (gain_bin_reg != '1))
            begin
                gain_bin_next = gain_bin_reg + COUNT_WIDTH'(1);
            end
            if (loss_hit && (loss_bin_reg != '1))
            begin
                loss_bin_next = loss_bin_reg + COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            gain_pend_reg <= 1'b0;
            loss_pend_reg <= 1'b0;
            gain_bin_reg  <= '0;
            loss_bin_reg  <= '0;
        end
        else
        begin
            valid_reg     <= valid_next;
            gain_pend_reg <= gain_pend_next;
            loss_pend_reg <= loss_pend_next;
            gain_bin_reg  <= gain_bin_next;
            loss_bin_reg  <= loss_bin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            value_reg <= prev_value;
        end
    end

    // A flag handed to the next cell already reflects a hit in this cycle.
    assign value     = value_reg;
    assign valid     = valid_reg;
    assign gain_pend = gain_pend_reg && !gain_hit;
    assign loss_pend = loss_pend_reg && !loss_hit;
    assign gain_bin  = gain_bin_reg;
    assign loss_bin  = loss_bin_reg;

endmodule
